### hw/rtl/f2f8_pkg.sv
// Package: shared constants and types for the FP32 to FP8 converter.
package f2f8_pkg;
    localparam logic [7:0] C_NAN       = 8'h7F;
    localparam logic [6:0] C_E4_MAXMAG = 7'h7E;
    localparam logic [6:0] C_E5_INF    = 7'h7C;
    localparam logic [6:0] C_E5_MAXMAG = 7'h7B;
    localparam logic [0:0] C_REG_FORMAT   = 1'b0;
    localparam logic [0:0] C_REG_SATURATE = 1'b1;

    typedef struct packed {
        logic        nan;
        logic        ovf;
        logic        zero;
        logic        sign;
        logic        e5;
        logic        sat;
    } t_flags;
endpackage

### hw/rtl/fp32_to_fp8_narrow_convert.sv
// Top level: pipelined FP32 to FP8 (E4M3 / E5M2) converter with RNE rounding.
//
// Channels: s_axis carries one FP32 bit pattern per transfer in tdata[31:0];
// m_axis returns one FP8 byte per transfer in tdata[7:0]. A transfer happens
// on a rising edge with tvalid and tready both high.
// Configuration: i_cfg_we writes register i_cfg_idx (0 = target format,
// 1 = saturate) with i_cfg_wdata[0]; write only while the pipe is empty.
// Path: an input item passes through three register stages in order and is
// offered on m_axis from the third.
// Throughput: one item per cycle while m_axis_tready stays high, through the
// three-stage pipeline (decode/align, round, pack), one register per stage.
// Stall: when m_axis_tready is low a full output stage holds; s_axis_tready
// drops only when all three stages are full and the output is stalled, so
// earlier empty stages still fill (bubbles collapse).
// Reset (synchronous, active low): valid bits and config registers clear;
// format returns to E4M3, saturation off.
module fp32_to_fp8_narrow_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] source_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] fp8_bits
);
    import f2f8_pkg::*;

    logic r_fmt, r_sat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
            r_sat <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == C_REG_FORMAT)   r_fmt <= i_cfg_wdata;
            if (i_cfg_idx == C_REG_SATURATE) r_sat <= i_cfg_wdata;
        end
    end

    // Per-stage enables: a stage advances when the next one can accept.
    logic r_v1, r_v2, r_v3;
    logic en3, en2, en1;
    assign en3 = !r_v3 || m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    // Stage 1: decode, pick shift amount, flag specials.
    logic [7:0]  e;
    logic [22:0] f;
    logic [8:0]  ebias;
    logic [1:0]  mb;
    logic [8:0]  s_sub;
    logic [5:0]  n_sh;
    t_flags      n_fl1;
    logic        sub;
    logic [7:0]  n_eb;
    always_comb begin
        e     = s_axis_tdata[30:23];
        f     = s_axis_tdata[22:0];
        mb    = r_fmt ? 2'd2 : 2'd3;
        ebias = {1'b0, e} + (r_fmt ? 9'd15 : 9'd7);
        sub   = ebias < 9'd128;
        s_sub = 9'd151 - ebias - {7'd0, mb};
        if (sub) n_sh = (s_sub >= 9'd32) ? 6'd32 : s_sub[5:0];
        else     n_sh = {4'd0, 2'd0} + (6'd23 - {4'd0, mb});
        // biased FP8 exponent for normal path
        n_eb = ebias[7:0] - 8'd127;
        n_fl1.nan  = (e == 8'hFF) && (f != 23'd0);
        n_fl1.ovf  = (e == 8'hFF) ||
                     ({1'b0, e} > (r_fmt ? 9'd142 : 9'd135));
        n_fl1.zero = (e == 8'd0);
        n_fl1.sign = s_axis_tdata[31];
        n_fl1.e5   = r_fmt;
        n_fl1.sat  = r_sat;
        if (sub) n_eb = 8'd0;
    end

    logic [23:0] r_m1;
    logic [5:0]  r_sh1;
    logic [7:0]  r_eb1;
    t_flags      r_fl1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en1) r_v1 <= s_axis_tvalid;
        if (en1) begin
            r_m1  <= {1'b1, f};
            r_sh1 <= n_sh;
            r_eb1 <= n_eb;
            r_fl1 <= n_fl1;
        end
    end

    // Stage 2: shift with round to nearest even.
    logic [23:0] q, rem, half, lmask;
    logic [23:0] n_q2;
    always_comb begin
        if (r_sh1 >= 6'd24) begin
            q = 24'd0; lmask = 24'hFFFFFF;
        end else begin
            q = r_m1 >> r_sh1[4:0]; lmask = (24'd1 << r_sh1[4:0]) - 24'd1;
        end
        rem  = r_m1 & lmask;
        half = (r_sh1 == 6'd0) ? 24'd0 :
               ((r_sh1 >= 6'd25) ? 24'hFFFFFF : (24'd1 << (r_sh1[4:0] - 5'd1)));
        // shift of 24: rem is m itself, half is 2^23
        if (r_sh1 == 6'd24) half = 24'h800000;
        n_q2 = q;
        if (r_sh1 != 6'd0 && r_sh1 <= 6'd24 &&
            (rem > half || (rem == half && q[0]))) n_q2 = q + 24'd1;
    end

    logic [4:0] r_q2;
    logic [7:0] r_eb2;
    t_flags     r_fl2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en2) r_v2 <= r_v1;
        if (en2) begin
            r_q2  <= n_q2[4:0];
            r_eb2 <= r_eb1;
            r_fl2 <= r_fl1;
        end
    end

    // Stage 3: assemble magnitude, apply overflow and special codes.
    logic [8:0] mag;
    logic [7:0] ovr, n_out;
    always_comb begin
        if (r_eb2 == 8'd0)
            mag = {4'd0, r_q2};
        else if (r_fl2.e5)
            mag = ({1'b0, r_eb2} << 2) + {4'd0, r_q2} - 9'd4;
        else
            mag = ({1'b0, r_eb2} << 3) + {4'd0, r_q2} - 9'd8;
        if (r_fl2.e5)
            ovr = {r_fl2.sign, r_fl2.sat ? C_E5_MAXMAG : C_E5_INF};
        else
            ovr = r_fl2.sat ? {r_fl2.sign, C_E4_MAXMAG} : C_NAN;
        if (r_fl2.nan)       n_out = C_NAN;
        else if (r_fl2.ovf)  n_out = ovr;
        else if (r_fl2.zero) n_out = {r_fl2.sign, 7'd0};
        else if (mag > {2'd0, r_fl2.e5 ? C_E5_MAXMAG : C_E4_MAXMAG}) n_out = ovr;
        else                 n_out = {r_fl2.sign, mag[6:0]};
    end

    logic [7:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en3) r_v3 <= r_v2;
        if (en3) r_out <= n_out;
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !m_axis_tready |=> r_v3 && $stable(r_out))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v1 && r_v2 && r_v3 && !m_axis_tready)
        else $error("input stalled with room in pipe");
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en3 && r_v2 && r_fl2.nan |=> r_out == C_NAN)
        else $error("NaN not mapped to canonical code");
endmodule
